/* hdl/stpc_pkg.sv */
// ----------------------------------------------------------------------------
// stpc_pkg
// Character code table and shared constants for the symbol to penta cipher.
// ----------------------------------------------------------------------------
package stpc_pkg;

   localparam int unsigned CHAR_W   = 16;
   localparam int unsigned VALUE_W  = 35;
   localparam int unsigned LEN_W    = 6;
   localparam int unsigned CIPHER_W = 32;
   localparam int unsigned LOW_W    = 30;

   localparam logic [LEN_W-1:0]    MAX_BITS     = 6'd35;
   localparam logic [LEN_W-1:0]    SHORT_BITS   = 6'd30;
   localparam logic [LEN_W-1:0]    NARROW_LEN   = 6'd5;
   localparam logic [LEN_W-1:0]    WIDE_LEN     = 6'd10;
   localparam logic [9:0]          WIDE_BASE    = 10'h3C0;
   localparam logic [4:0]          CODE_DOT     = 5'd27;
   localparam logic [4:0]          CODE_SLASH   = 5'd28;
   localparam logic [4:0]          CODE_DOLLAR  = 5'd29;
   localparam logic [1:0]          TAG_SHORT    = 2'b01;
   localparam logic [1:0]          TAG_SLASH    = 2'b10;
   localparam logic [1:0]          TAG_DOLLAR   = 2'b11;
   localparam logic [CIPHER_W-1:0] CIPHER_NONE  = 32'h0000_0000;

   typedef struct packed {
      logic       ok;
      logic       wide;
      logic [9:0] code;
   } char_code_type;

   function automatic char_code_type char_code(input logic [CHAR_W-1:0] ch);
      char_code_type r;
      logic [6:0]    c;
      logic [6:0]    off;
      logic [6:0]    rank;
      c    = ch[6:0];
      off  = 7'h00;
      r.ok   = 1'b1;
      r.wide = 1'b0;
      r.code = 10'd0;
      if (ch[CHAR_W-1:7] != '0) begin
         r.ok = 1'b0;
      end else if (c >= 7'h41 && c <= 7'h5A) begin
         r.code = {3'b000, c - 7'h40};
      end else if (c == 7'h2E) begin
         r.code = {5'b00000, CODE_DOT};
      end else if (c == 7'h2F) begin
         r.code = {5'b00000, CODE_SLASH};
      end else if (c == 7'h24) begin
         r.code = {5'b00000, CODE_DOLLAR};
      end else if (c < 7'h20 || c == 7'h7F || c == 7'h27 || c == 7'h60) begin
         r.ok = 1'b0;
      end else begin
         if (c <= 7'h23) begin
            off = 7'h20;
         end else if (c <= 7'h26) begin
            off = 7'h21;
         end else if (c <= 7'h2D) begin
            off = 7'h22;
         end else if (c <= 7'h40) begin
            off = 7'h24;
         end else if (c <= 7'h5F) begin
            off = 7'h3E;
         end else begin
            off = 7'h3F;
         end
         rank   = c - off;
         r.wide = 1'b1;
         r.code = WIDE_BASE + {4'b0000, rank[5:0]};
      end
      return r;
   endfunction

endpackage

/* hdl/symbol_to_penta_cipher_top.sv */
// ----------------------------------------------------------------------------
// symbol_to_penta_cipher_top
// Packs a ticker symbol, one character per transaction, into a 32-bit cipher.
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_stall   | character, no_character, last
//   rsp_    | out       | rsp_valid / rsp_stall   | cipher, encodable
//
// One character per cycle unless req_stall holds it; a last transaction passes
// the input register, then the result register, before its result leaves.
// The accumulator update is the single stage between the two registers.
// Reset (synchronous) clears both valid flags and the accumulator state.
// A stalled result holds; non-last characters keep flowing past it, a last
// one waits in the input register until the result register frees.
// ----------------------------------------------------------------------------
module symbol_to_penta_cipher_top
   import stpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic                req_no_character,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CIPHER_W-1:0] rsp_cipher,
   output logic                rsp_encodable
);

   logic                s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0]   s1_char_ff;
   logic                s1_none_ff;
   logic                s1_last_ff;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                failed_ff, failed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CIPHER_W-1:0] cipher_ff, cipher_in;
   logic                encodable_ff, encodable_in;

   logic                req_take;
   logic                s1_adv;
   logic                out_free;
   char_code_type       cc;
   logic [LEN_W-1:0]    code_len;
   logic [LEN_W-1:0]    sum_len;
   logic [VALUE_W-1:0]  upd_value;
   logic [LEN_W-1:0]    upd_len;
   logic                upd_failed;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cc         = char_code(s1_char_ff);
      code_len   = cc.wide ? WIDE_LEN : NARROW_LEN;
      sum_len    = len_ff + code_len;
      upd_value  = value_ff;
      upd_len    = len_ff;
      upd_failed = failed_ff;
      if (!s1_none_ff && !failed_ff) begin
         if (!cc.ok) begin
            upd_failed = 1'b1;
         end else if (sum_len > MAX_BITS) begin
            upd_failed = 1'b1;
            upd_len    = MAX_BITS;
         end else begin
            upd_value = (cc.wide ? {value_ff[VALUE_W-11:0], 10'd0}
                                 : {value_ff[VALUE_W-6:0], 5'd0})
                        + {{(VALUE_W-10){1'b0}}, cc.code};
            upd_len   = sum_len;
         end
      end

      if (upd_failed) begin
         cipher_in = CIPHER_NONE;
      end else if (upd_len <= SHORT_BITS) begin
         cipher_in = {TAG_SHORT, upd_value[LOW_W-1:0]};
      end else if (upd_value[VALUE_W-1:LOW_W] == CODE_SLASH) begin
         cipher_in = {TAG_SLASH, upd_value[LOW_W-1:0]};
      end else if (upd_value[VALUE_W-1:LOW_W] == CODE_DOLLAR) begin
         cipher_in = {TAG_DOLLAR, upd_value[LOW_W-1:0]};
      end else begin
         cipher_in = CIPHER_NONE;
      end
      encodable_in = (cipher_in != CIPHER_NONE);

      value_in  = value_ff;
      len_in    = len_ff;
      failed_in = failed_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            value_in  = '0;
            len_in    = '0;
            failed_in = 1'b0;
         end else begin
            value_in  = upd_value;
            len_in    = upd_len;
            failed_in = upd_failed;
         end
      end

      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         value_ff     <= '0;
         len_ff       <= '0;
         failed_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         value_ff     <= value_in;
         len_ff       <= len_in;
         failed_ff    <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_character;
         s1_none_ff <= req_no_character;
         s1_last_ff <= req_last;
      end
      if (s1_adv && s1_last_ff) begin
         cipher_ff    <= cipher_in;
         encodable_ff <= encodable_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cipher    = cipher_ff;
   assign rsp_encodable = encodable_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MAX_BITS)
      else $error("bit length above limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (len_ff == '0 && !failed_ff && value_ff == '0))
      else $error("state not cleared after last character");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked last character");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_last_ff))
      else $error("result raised without a last character");

endmodule
